@@ hdl/twg_pkg.sv @@
// Shared types and constants for the test waveform generator.
// No dependencies; every other file imports this package.
package twg_pkg;

  localparam logic [2:0] REG_WAVEFORM    = 3'd0;
  localparam logic [2:0] REG_STEP_FIRST  = 3'd1;
  localparam logic [2:0] REG_STEP_SECOND = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE   = 3'd3;
  localparam logic [2:0] REG_COUNT       = 3'd4;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_DUAL   = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_NOISE  = 2'd3;

  localparam logic [15:0] NOISE_SEED   = 16'hACE1;
  localparam logic [15:0] NOISE_OFFSET = 16'h4000;

  localparam logic signed [15:0] W_FIRST  = 16'sd22938;
  localparam logic signed [15:0] W_SECOND = 16'sd9830;
  localparam logic signed [31:0] SQ_POS   = 32'sd32767;
  localparam logic signed [31:0] SQ_NEG   = -32'sd32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic [1:0]  waveform;
    logic [31:0] step_first;
    logic [31:0] step_second;
    logic [14:0] amplitude;
    logic [15:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic weight;
    logic sum;
    logic scale;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ hdl/twg_cfg.sv @@
// Configuration register file for the test waveform generator.
// Depends on twg_pkg for register indexes and the cfg_t bundle.
module twg_cfg import twg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform     <= WAVE_SINE;
      cfg.step_first   <= '0;
      cfg.step_second  <= '0;
      cfg.amplitude    <= 15'd32767;
      cfg.sample_count <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WAVEFORM:    cfg.waveform     <= cfg_data[1:0];
        REG_STEP_FIRST:  cfg.step_first   <= cfg_data;
        REG_STEP_SECOND: cfg.step_second  <= cfg_data;
        REG_AMPLITUDE:   cfg.amplitude    <= cfg_data[14:0];
        REG_COUNT:       cfg.sample_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/twg_sine_rom.sv @@
// Dual-read sine ROM, Q1.15, contents built at elaboration.
// Depends on twg_pkg for the fixed-point constants of the series.
module twg_sine_rom import twg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic [ADDR_W-1:0]        addr_a,
  input  logic [ADDR_W-1:0]        addr_b,
  output logic signed [15:0]       data_a,
  output logic signed [15:0]       data_b
);

  typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

  // Taylor series to x^11 on the folded first quadrant, Q30
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] quarter;
    logic [63:0] rem;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [15:0] mag;
    quarter = (64'(4 * k)) / SINE_TABLE_DEPTH;
    rem     = (64'(4 * k)) % SINE_TABLE_DEPTH;
    u       = (rem << 30) / SINE_TABLE_DEPTH;
    if (quarter[0]) u = ONE_Q30 - u;
    x    = (u * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = signed'(x);
    term = ((x * x2) >> 30) / 6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - signed'(term);
    if (sum < 0) sum = 0;
    sum = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
    if (sum > 64'sd32767) sum = 64'sd32767;
    mag = sum[15:0];
    return (quarter >= 64'd2) ? -mag : mag;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) r[k] = sine_entry(k);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data_a <= SINE_ROM[addr_a];
    data_b <= SINE_ROM[addr_b];
  end

endmodule

@@ hdl/twg_ctrl.sv @@
// Sequencing state machine for the test waveform generator.
// Depends on twg_pkg for the command and status bundles.
module twg_ctrl import twg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROM    = 3'd1;
  localparam logic [2:0] ST_WEIGHT = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_ROM;
        end
      end
      ST_ROM:    state_next = ST_WEIGHT;
      ST_WEIGHT: begin
        cmd.weight = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/twg_dp.sv @@
// Datapath: phase accumulators, noise LFSR, sample counter, scaling, output register.
// Depends on twg_pkg; reads the sine ROM through registered ports.
module twg_dp import twg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic                  restart,
  output logic [ADDR_W-1:0]     rom_addr_a,
  output logic [ADDR_W-1:0]     rom_addr_b,
  input  logic signed [15:0]    rom_data_a,
  input  logic signed [15:0]    rom_data_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_sample,
  output logic                  out_last
);

  localparam int IDX_W = PHASE_BITS + ADDR_W + 1;

  logic [PHASE_BITS-1:0] phase_first;
  logic [PHASE_BITS-1:0] phase_second;
  logic [15:0]           noise_reg;
  logic [15:0]           sample_index;

  logic [PHASE_BITS-1:0] p1_eff;
  logic [PHASE_BITS-1:0] p2_eff;
  logic [15:0]           noise_eff;
  logic [15:0]           noise_step;
  logic [15:0]           idx_eff;
  logic                  last_calc;
  logic [IDX_W-1:0]      idx_prod_a;
  logic [IDX_W-1:0]      idx_prod_b;

  logic [1:0]            wave_q;
  logic                  sq_neg;
  logic signed [15:0]    noise_val;
  logic                  last_q;
  logic signed [31:0]    prod1;
  logic signed [31:0]    prod2;
  logic signed [31:0]    opnd;
  logic signed [47:0]    prod;

  logic signed [47:0]    bias;
  logic signed [47:0]    biased;
  logic signed [47:0]    quot;
  logic [15:0]           sat;

  always_comb begin
    p1_eff     = restart ? '0 : phase_first;
    p2_eff     = restart ? '0 : phase_second;
    noise_eff  = restart ? NOISE_SEED : noise_reg;
    idx_eff    = restart ? '0 : sample_index;
    noise_step = {noise_eff[0] ^ noise_eff[2] ^ noise_eff[3] ^ noise_eff[5], noise_eff[15:1]};
    last_calc  = ({1'b0, idx_eff} + 17'd1) >= {1'b0, cfg.sample_count};
    idx_prod_a = IDX_W'(p1_eff) * IDX_W'(SINE_TABLE_DEPTH);
    idx_prod_b = IDX_W'(p2_eff) * IDX_W'(SINE_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_first  <= '0;
      phase_second <= '0;
      noise_reg    <= NOISE_SEED;
      sample_index <= '0;
    end else if (cmd.start) begin
      if (last_calc) begin
        phase_first  <= '0;
        phase_second <= '0;
        noise_reg    <= NOISE_SEED;
        sample_index <= '0;
      end else begin
        phase_first  <= p1_eff + PHASE_BITS'(cfg.step_first);
        phase_second <= p2_eff + PHASE_BITS'(cfg.step_second);
        noise_reg    <= (cfg.waveform == WAVE_NOISE) ? noise_step : noise_eff;
        sample_index <= idx_eff + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rom_addr_a <= idx_prod_a[PHASE_BITS +: ADDR_W];
      rom_addr_b <= idx_prod_b[PHASE_BITS +: ADDR_W];
      wave_q     <= cfg.waveform;
      sq_neg     <= p1_eff[PHASE_BITS-1];
      noise_val  <= signed'(noise_step - NOISE_OFFSET);
      last_q     <= last_calc;
    end
    if (cmd.weight) begin
      prod1 <= 32'(rom_data_a) * 32'(W_FIRST);
      prod2 <= 32'(rom_data_b) * 32'(W_SECOND);
    end
    if (cmd.sum) begin
      case (wave_q)
        WAVE_SINE:   opnd <= 32'(rom_data_a);
        WAVE_DUAL:   opnd <= prod1 + prod2;
        WAVE_SQUARE: opnd <= sq_neg ? SQ_NEG : SQ_POS;
        default:     opnd <= 32'(noise_val);
      endcase
    end
    if (cmd.scale) begin
      prod <= 48'(opnd) * 48'(signed'({1'b0, cfg.amplitude}));
    end
  end

  // truncate toward zero, then saturate to int16
  always_comb begin
    if (prod[47]) begin
      bias = (wave_q == WAVE_DUAL) ? 48'sd1073741823 : 48'sd32767;
    end else begin
      bias = '0;
    end
    biased = prod + bias;
    quot   = (wave_q == WAVE_DUAL) ? (biased >>> 30) : (biased >>> 15);
    if (quot > 48'sd32767) begin
      sat = 16'h7FFF;
    end else if (quot < -48'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = quot[15:0];
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sample <= sat;
      out_last   <= last_q;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && last_calc) |=> (sample_index == '0 && phase_first == '0))
    else $error("buffer state not cleared after last sample");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("output register overwritten while occupied");

  a_noise_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && !restart && !last_calc && cfg.waveform != WAVE_NOISE)
      |=> (noise_reg == $past(noise_reg)))
    else $error("noise register stepped on a non-noise sample");

endmodule

@@ hdl/test_waveform_generator.sv @@
// Top level of the test waveform generator: config, controller, datapath, sine ROM.
// Depends on twg_pkg, twg_cfg, twg_ctrl, twg_dp and twg_sine_rom.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata[0] restart
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata[15:0] sample, tlast last
//   cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// Per sample, in order: accept, ROM read, weighting multiply, operand
// select, amplitude multiply, then the truncated result enters the output register.
// The next beat is taken only once that result has entered the output register,
// while the result may still wait downstream.
// Reset is synchronous; the sine ROM needs no clearing. A stalled output holds
// the controller in its final step until the output register frees up.
module test_waveform_generator import twg_pkg::*; #(
  parameter int PHASE_BITS = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);

  cfg_t               cfg;
  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic [ADDR_W-1:0]  rom_addr_a;
  logic [ADDR_W-1:0]  rom_addr_b;
  logic signed [15:0] rom_data_a;
  logic signed [15:0] rom_data_b;

  twg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  twg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  twg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .addr_a (rom_addr_a),
    .addr_b (rom_addr_b),
    .data_a (rom_data_a),
    .data_b (rom_data_b)
  );

  twg_dp #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .restart    (s_axis_tdata[0]),
    .rom_addr_a (rom_addr_a),
    .rom_addr_b (rom_addr_b),
    .rom_data_a (rom_data_a),
    .rom_data_b (rom_data_b),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
